FILE: rtl/ostt_pkg.sv
package ostt_pkg;

  // Table size and derived slot index width.
  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int PORT_W     = 16;
  localparam int DELAY_W    = 32;
  localparam int NOW_W      = 48;
  localparam int DUE_W      = 49;
  localparam int KIND_W     = 3;
  localparam int INDEX_W    = 6;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_ARM      = 2'd0,
    OP_DEAD     = 2'd1,
    OP_EXPIRE   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ARMED = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_FIRED = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_DEAD  = 3'd4
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_MARK,
    ST_EXPIRE,
    ST_FINAL
  } state_t;

  // Update request from the sequencer to the slot file.
  typedef struct packed {
    logic              wr_en;
    logic              clr_en;
    logic              mark_en;
    logic              purge;
    logic [SLOT_W-1:0] idx;
    logic [PORT_W-1:0] port;
    logic [DUE_W-1:0]  due;
  } slot_cmd_t;

  // Contents of the slot under the scan pointer.
  typedef struct packed {
    logic              valid;
    logic              dead;
    logic [PORT_W-1:0] port;
    logic [DUE_W-1:0]  due;
  } slot_rd_t;

endpackage

FILE: rtl/ostt_slot_file.sv
module ostt_slot_file (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ostt_pkg::slot_cmd_t         cmd,
  input  logic [ostt_pkg::SLOT_W-1:0] rd_idx,
  output ostt_pkg::slot_rd_t          rd
);
  import ostt_pkg::*;

  logic [TIMER_SLOTS-1:0] valid_r;
  logic [TIMER_SLOTS-1:0] valid_nxt;
  logic [TIMER_SLOTS-1:0] dead_r;
  logic [TIMER_SLOTS-1:0] dead_nxt;
  logic [PORT_W-1:0]      port_r [TIMER_SLOTS];
  logic [DUE_W-1:0]       due_r  [TIMER_SLOTS];

  // Status bits: a purge frees every dead slot; a write on the same cycle wins.
  always_comb begin
    valid_nxt = valid_r;
    dead_nxt  = dead_r;
    if (cmd.purge) begin
      valid_nxt = valid_r & ~dead_r;
      dead_nxt  = '0;
    end
    if (cmd.clr_en) begin
      valid_nxt[cmd.idx] = 1'b0;
      dead_nxt[cmd.idx]  = 1'b0;
    end
    if (cmd.mark_en) begin
      dead_nxt[cmd.idx] = 1'b1;
    end
    if (cmd.wr_en) begin
      valid_nxt[cmd.idx] = 1'b1;
      dead_nxt[cmd.idx]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dead_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      dead_r  <= dead_nxt;
    end
  end

  // Port and deadline storage is only read behind a valid bit.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      port_r[cmd.idx] <= cmd.port;
      due_r[cmd.idx]  <= cmd.due;
    end
  end

  // The slot under the scan pointer.
  assign rd.valid = valid_r[rd_idx];
  assign rd.dead  = dead_r[rd_idx];
  assign rd.port  = port_r[rd_idx];
  assign rd.due   = due_r[rd_idx];

endmodule

FILE: rtl/one_shot_timer_table_core.sv
// An arm scans from slot zero up to the first free slot, where its result is loaded.
// A port-dead request and an expire scan load their last result once the walk is done, and
// stall while output backpressure holds a result back; both walk all 32 slots with one
// compare unit, one slot a cycle except while an expire scan holds on a due slot.
// Throughput: one request at a time, taken again on the cycle after its last result is loaded.
// Reset clears the sequencer, the output valid flag and all valid and dead bits.
module one_shot_timer_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ostt_pkg::IN_DATA_W-1:0]  in_tdata,  // port_id[15:0], delay_ms[47:16], now_ms[95:48]
  input  logic [ostt_pkg::OP_W-1:0]       in_tuser,  // operation[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ostt_pkg::OUT_DATA_W-1:0] out_tdata, // fired_port[15:0], slot_index[21:16], zero
  output logic [ostt_pkg::KIND_W-1:0]     out_tuser, // kind[2:0]
  output logic                            out_tlast
);
  import ostt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [DUE_W-1:0]  due_r, due_nxt;
  logic              dead_seen_r, dead_seen_nxt;
  logic [SLOT_W-1:0] dead_idx_r, dead_idx_nxt;
  kind_t             fin_kind_r, fin_kind_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [PORT_W-1:0]  out_port_r, out_port_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_last_r, out_last_nxt;

  slot_cmd_t         cmd;
  slot_rd_t          rd;
  logic              out_free;
  logic              at_last;
  logic [DUE_W:0]    diff;
  logic              due_hit;
  logic              port_hit;
  logic              emit;
  kind_t             emit_kind;
  logic [PORT_W-1:0] emit_port;
  logic [SLOT_W-1:0] emit_idx;
  logic              emit_last;
  logic [SLOT_W-1:0] arm_idx;

  ostt_slot_file u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .rd_idx (idx_r),
    .rd     (rd)
  );

  // Shared compare unit: deadline check and port match on the slot under the pointer.
  assign diff     = {2'b00, now_r} - {1'b0, rd.due};
  assign due_hit  = ~diff[DUE_W];
  assign port_hit = (rd.port == port_r);

  assign out_free  = !out_valid_r || out_tready;
  assign at_last   = (idx_r == LAST_IDX);
  assign in_tready = (state_r == ST_IDLE);
  assign arm_idx   = dead_seen_r ? dead_idx_r : idx_r;

  // Sequencer: next state, slot updates and result generation.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    port_nxt      = port_r;
    now_nxt       = now_r;
    due_nxt       = due_r;
    dead_seen_nxt = dead_seen_r;
    dead_idx_nxt  = dead_idx_r;
    fin_kind_nxt  = fin_kind_r;
    cmd           = '0;
    cmd.port      = port_r;
    cmd.due       = due_r;
    cmd.idx       = idx_r;
    emit          = 1'b0;
    emit_kind     = KIND_DONE;
    emit_port     = '0;
    emit_idx      = '0;
    emit_last     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid) begin
          port_nxt      = in_tdata[PORT_W-1:0];
          now_nxt       = in_tdata[IN_DATA_W-1 -: NOW_W];
          due_nxt       = DUE_W'(in_tdata[IN_DATA_W-1 -: NOW_W])
                        + DUE_W'(in_tdata[PORT_W +: DELAY_W]);
          dead_seen_nxt = 1'b0;
          case (op_t'(in_tuser))
            OP_ARM: begin
              state_nxt = ST_ARM;
            end
            OP_DEAD: begin
              state_nxt    = ST_MARK;
              fin_kind_nxt = KIND_DEAD;
            end
            OP_EXPIRE: begin
              // Dead slots are dropped before any deadline is examined.
              cmd.purge    = 1'b1;
              state_nxt    = ST_EXPIRE;
              fin_kind_nxt = KIND_DONE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ARM: begin
        if (!rd.valid) begin
          if (out_free) begin
            cmd.wr_en = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_ARMED;
            emit_port = port_r;
            emit_idx  = idx_r;
            state_nxt = ST_IDLE;
            idx_nxt   = '0;
          end
        end else begin
          if (rd.dead && !dead_seen_r) begin
            dead_seen_nxt = 1'b1;
            dead_idx_nxt  = idx_r;
          end
          if (at_last) begin
            if (out_free) begin
              emit      = 1'b1;
              emit_port = port_r;
              state_nxt = ST_IDLE;
              idx_nxt   = '0;
              if (dead_seen_r || rd.dead) begin
                // Table full: free the dead slots and reuse the lowest of them.
                cmd.purge = 1'b1;
                cmd.wr_en = 1'b1;
                cmd.idx   = arm_idx;
                emit_kind = KIND_ARMED;
                emit_idx  = arm_idx;
              end else begin
                emit_kind = KIND_FULL;
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_MARK: begin
        cmd.mark_en = rd.valid && port_hit;
        if (at_last) begin
          state_nxt = ST_FINAL;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EXPIRE: begin
        if (rd.valid && due_hit && !out_free) begin
          // Hold on this slot until the output register frees up.
          idx_nxt = idx_r;
        end else begin
          if (rd.valid && due_hit) begin
            cmd.clr_en = 1'b1;
            emit       = 1'b1;
            emit_kind  = KIND_FIRED;
            emit_port  = rd.port;
            emit_idx   = idx_r;
            emit_last  = 1'b0;
          end
          if (at_last) begin
            state_nxt = ST_FINAL;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = fin_kind_r;
          emit_port = (fin_kind_r == KIND_DEAD) ? port_r : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // Output register: loads a new result or drains on a transaction.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_port_nxt  = out_port_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_kind;
      out_port_nxt  = emit_port;
      out_index_nxt = INDEX_W'(emit_idx);
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      dead_seen_r <= 1'b0;
      fin_kind_r  <= KIND_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      dead_seen_r <= dead_seen_nxt;
      fin_kind_r  <= fin_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r      <= port_nxt;
    now_r       <= now_nxt;
    due_r       <= due_nxt;
    dead_idx_r  <= dead_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_port_r  <= out_port_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DATA_W - PORT_W - INDEX_W){1'b0}}, out_index_r, out_port_r};
  assign out_tlast  = out_last_r;

  // Only fired results leave a request open; every other kind closes it.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_FIRED) == !out_last_r))
    else $error("tlast does not match the result kind");

  // A request with a defined code keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != OP_RESERVED)) |=> !in_tready)
    else $error("input accepted again without a scan");

  // The scan pointer always starts from slot zero.
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (idx_r == '0))
    else $error("scan pointer not cleared while idle");

  // A fired result is only loaded for a slot whose deadline has passed.
  a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (emit_kind == KIND_FIRED)) |-> (rd.valid && due_hit))
    else $error("timer fired before its deadline");

endmodule
